// ===== rtl/kftl_pkg.sv =====
// Package: widths, constants and word types of the keyed fragment table.
`default_nettype none
package kftl_pkg;

	// table geometry
	localparam int SLOTS     = 2;
	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int FRAGMENTS = 16;
	localparam int FRAG_W    = (FRAGMENTS > 1) ? $clog2(FRAGMENTS) : 1;
	localparam int STORE_D   = SLOTS * FRAGMENTS;
	localparam int STORE_AW  = (STORE_D > 1) ? $clog2(STORE_D) : 1;

	// field widths
	localparam int KEY_W  = 32;
	localparam int NUM_W  = 8;
	localparam int DATA_W = 48;
	localparam int TIME_W = 32;
	localparam int ID_W   = 8;

	// decoded fragment, handed from the front end to the back end
	typedef struct packed {
		logic [KEY_W-1:0]  frequency_key;
		logic              frag_ok;
		logic [FRAG_W-1:0] frag_idx;
		logic [DATA_W-1:0] fragment_data;
		logic [TIME_W-1:0] timestamp;
	} cmd_t;

	// result word
	typedef struct packed {
		logic [SLOT_W-1:0]    slot_index;
		logic [ID_W-1:0]      sender_id;
		logic                 was_new;
		logic [FRAGMENTS-1:0] valid_flags;
		logic                 calib_complete;
	} rsp_t;

endpackage
`default_nettype wire

// ===== rtl/kftl_if.sv =====
// Interfaces: fragment request channel and result channel.
`default_nettype none
interface kftl_req_if
	import kftl_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [KEY_W-1:0]  frequency_key;
	logic [NUM_W-1:0]  fragment_number;
	logic [DATA_W-1:0] fragment_data;
	logic [TIME_W-1:0] timestamp;

	modport source (output valid, frequency_key, fragment_number, fragment_data, timestamp,
		input ready);
	modport sink (input valid, frequency_key, fragment_number, fragment_data, timestamp,
		output ready);
endinterface

interface kftl_rsp_if
	import kftl_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [SLOT_W-1:0]    slot_index;
	logic [ID_W-1:0]      sender_id;
	logic                 was_new;
	logic [FRAGMENTS-1:0] valid_flags;
	logic                 calib_complete;

	modport source (output valid, slot_index, sender_id, was_new, valid_flags, calib_complete,
		input ready);
	modport sink (input valid, slot_index, sender_id, was_new, valid_flags, calib_complete,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/kftl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kftl_ram #(
	parameter int W = 8,
	parameter int D = 32
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output      logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/kftl_front.sv =====
// Front end: takes fragment words and decodes the fragment number.
`default_nettype none
module kftl_front
	import kftl_pkg::*;
(
	kftl_req_if.sink  req,
	input  wire logic q_ready,
	output      logic q_push,
	output      cmd_t q_cmd
);

	logic frag_ok;

	// fragment numbers 1..FRAGMENTS are stored; any other number is not stored and sets no flag
	assign frag_ok = (req.fragment_number != '0) &&
		(req.fragment_number <= NUM_W'(FRAGMENTS));

	assign req.ready = q_ready;
	assign q_push    = req.valid && q_ready;

	always_comb begin
		q_cmd.frequency_key = req.frequency_key;
		q_cmd.frag_ok       = frag_ok;
		q_cmd.frag_idx      = FRAG_W'(req.fragment_number - NUM_W'(1));
		q_cmd.fragment_data = req.fragment_data;
		q_cmd.timestamp     = req.timestamp;
	end

endmodule
`default_nettype wire

// ===== rtl/kftl_cmd_q.sv =====
// Two-entry command queue between front end and back end.
`default_nettype none
module kftl_cmd_q
	import kftl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output      logic push_ready,
	input  wire logic pop,
	output      logic pop_valid,
	output      cmd_t pop_cmd
);

	cmd_t       ent_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_cmd    = ent_q[rptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/kftl_back.sv =====
// Back end: slot lookup, table update, fragment store write and result register.
`default_nettype none
module kftl_back
	import kftl_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_valid,
	input  wire cmd_t                 q_cmd,
	output      logic                 q_pop,
	input  wire logic                 cfg_we,
	input  wire logic [FRAGMENTS-1:0] cfg_wdata,
	output      logic                 st_we,
	output      logic [STORE_AW-1:0]  st_addr,
	output      logic [DATA_W-1:0]    st_data,
	output      logic                 rsp_valid,
	input  wire logic                 rsp_ready,
	output      rsp_t                 rsp_word
);

	// slot table
	logic [KEY_W-1:0]     slot_key_q   [SLOTS];
	logic                 slot_used_q  [SLOTS];
	logic [TIME_W-1:0]    slot_time_q  [SLOTS];
	logic [ID_W-1:0]      slot_id_q    [SLOTS];
	logic [FRAGMENTS-1:0] slot_flags_q [SLOTS];
	logic [ID_W-1:0]      next_id_q;
	logic [FRAGMENTS-1:0] req_mask_q;

	// lookup stage
	logic              busy_s1;
	cmd_t              cmd_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              fresh_s1;

	// result register
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic                 advance;
	logic [SLOT_W-1:0]    pick_slot;
	logic                 pick_fresh;
	logic [FRAGMENTS-1:0] upd_flags;
	logic [ID_W-1:0]      upd_id;

	assign q_pop     = q_valid && !busy_s1;
	assign advance   = busy_s1 && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	// slot pick: key hit, else lowest empty slot, else oldest time (lowest index on tie)
	always_comb begin
		logic              hit;
		logic              empty;
		logic [SLOT_W-1:0] hit_idx;
		logic [SLOT_W-1:0] empty_idx;
		logic [SLOT_W-1:0] old_idx;
		hit       = 1'b0;
		empty     = 1'b0;
		hit_idx   = '0;
		empty_idx = '0;
		old_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (slot_used_q[i] && (slot_key_q[i] == q_cmd.frequency_key)) begin
				hit     = 1'b1;
				hit_idx = SLOT_W'(i);
			end
			if (!slot_used_q[i]) begin
				empty     = 1'b1;
				empty_idx = SLOT_W'(i);
			end
		end
		for (int i = 1; i < SLOTS; i++) begin
			if (slot_time_q[i] < slot_time_q[old_idx]) begin
				old_idx = SLOT_W'(i);
			end
		end
		pick_fresh = !hit;
		if (hit) begin
			pick_slot = hit_idx;
		end else if (empty) begin
			pick_slot = empty_idx;
		end else begin
			pick_slot = old_idx;
		end
	end

	// lookup stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (q_pop) begin
			busy_s1 <= 1'b1;
		end else if (advance) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1   <= q_cmd;
			slot_s1  <= pick_slot;
			fresh_s1 <= pick_fresh;
		end
	end

	// flags and ID of the slot after this fragment
	always_comb begin
		upd_flags = fresh_s1 ? '0 : slot_flags_q[slot_s1];
		if (cmd_s1.frag_ok) begin
			upd_flags[cmd_s1.frag_idx] = 1'b1;
		end
		upd_id = fresh_s1 ? next_id_q : slot_id_q[slot_s1];
	end

	// fragment store write
	assign st_we   = advance && cmd_s1.frag_ok;
	assign st_addr = STORE_AW'({slot_s1, cmd_s1.frag_idx});
	assign st_data = cmd_s1.fragment_data;

	// table update, ID counter and required mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_key_q[i]   <= '0;
				slot_used_q[i]  <= 1'b0;
				slot_time_q[i]  <= '0;
				slot_id_q[i]    <= '0;
				slot_flags_q[i] <= '0;
			end
			next_id_q  <= '0;
			req_mask_q <= '0;
		end else begin
			if (cfg_we) begin
				req_mask_q <= cfg_wdata;
			end
			if (advance) begin
				slot_used_q[slot_s1]  <= 1'b1;
				slot_key_q[slot_s1]   <= cmd_s1.frequency_key;
				slot_time_q[slot_s1]  <= cmd_s1.timestamp;
				slot_id_q[slot_s1]    <= upd_id;
				slot_flags_q[slot_s1] <= upd_flags;
				if (fresh_s1) begin
					next_id_q <= next_id_q + ID_W'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.slot_index     <= slot_s1;
			rsp_q.sender_id      <= upd_id;
			rsp_q.was_new        <= fresh_s1;
			rsp_q.valid_flags    <= upd_flags;
			rsp_q.calib_complete <= ((upd_flags & req_mask_q) == req_mask_q);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/keyed_fragment_table_lru.sv =====
// A word accepted at the input passes through the command queue, the lookup
// stage register and the result register. The back end takes no new word until
// the last has left the lookup stage (lookup, then update into the result register).
// A two-word command queue lets input words be taken while the back end stalls.
// Reset (arst_n low) clears slot table, ID counter, required mask and handshakes;
// the fragment RAM is not cleared.
`default_nettype none
module keyed_fragment_table_lru
	import kftl_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	kftl_req_if.sink                  req,
	kftl_rsp_if.source                rsp,
	input  wire logic                 cfg_we,
	input  wire logic [FRAGMENTS-1:0] cfg_wdata
);

	logic                q_push;
	logic                q_ready;
	cmd_t                q_in;
	logic                q_pop;
	logic                q_valid;
	cmd_t                q_out;
	logic                st_we;
	logic [STORE_AW-1:0] st_addr;
	logic [DATA_W-1:0]   st_data;
	rsp_t                rsp_word;

	kftl_front u_front (
		.req     (req),
		.q_ready (q_ready),
		.q_push  (q_push),
		.q_cmd   (q_in)
	);

	kftl_cmd_q u_cmd_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_in),
		.push_ready (q_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_cmd    (q_out)
	);

	kftl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_out),
		.q_pop     (q_pop),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.st_we     (st_we),
		.st_addr   (st_addr),
		.st_data   (st_data),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_word  (rsp_word)
	);

	// fragment store, write only in this design
	kftl_ram #(
		.W (DATA_W),
		.D (STORE_D)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_addr),
		.wdata (st_data),
		.raddr (st_addr),
		.rdata ()
	);

	assign rsp.slot_index     = rsp_word.slot_index;
	assign rsp.sender_id      = rsp_word.sender_id;
	assign rsp.was_new        = rsp_word.was_new;
	assign rsp.valid_flags    = rsp_word.valid_flags;
	assign rsp.calib_complete = rsp_word.calib_complete;

endmodule
`default_nettype wire

// ===== rtl/kftl_chk.sv =====
// Port checker for the keyed fragment table, bound to the top level.
`default_nettype none
module kftl_chk
	import kftl_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 req_valid,
	input wire logic                 req_ready,
	input wire logic                 rsp_valid,
	input wire logic                 rsp_ready,
	input wire rsp_t                 rsp_word,
	input wire logic                 cfg_we,
	input wire logic [FRAGMENTS-1:0] cfg_wdata
);

	logic [FRAGMENTS-1:0] mask_q;
	logic [2:0]           pend_q;

	// shadow of the required mask and count of words in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			pend_q <= '0;
		end else begin
			if (cfg_we) begin
				mask_q <= cfg_wdata;
			end
			pend_q <= pend_q + 3'(req_valid && req_ready) - 3'(rsp_valid && rsp_ready);
		end
	end

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
		else $error("result changed while stalled");

	// no result without a word in flight
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 3'd0)
		else $error("result without accepted word");

	// completeness follows flags and mask
	a_complete: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_word.calib_complete ==
			((rsp_word.valid_flags & mask_q) == mask_q))
		else $error("calib_complete disagrees with flags");

	// a fresh slot carries at most the one new flag
	a_fresh_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.was_new |-> $onehot0(rsp_word.valid_flags))
		else $error("fresh slot kept old flags");

endmodule

bind keyed_fragment_table_lru kftl_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_word  (rsp_word),
	.cfg_we    (cfg_we),
	.cfg_wdata (cfg_wdata)
);
`default_nettype wire

// ===== sim/tb_keyed_fragment_table_lru.sv =====
// Testbench for the keyed fragment table: directed, random and backpressure tests.
`timescale 1ns / 1ps

module tb_keyed_fragment_table_lru;
	import kftl_pkg::*;

	localparam logic [FRAGMENTS-1:0] MASK_NONE = '0;
	localparam logic [FRAGMENTS-1:0] MASK_ALL  = '1;
	localparam logic [KEY_W-1:0]     KEY_MAX   = '1;
	localparam logic [TIME_W-1:0]    TIME_MAX  = '1;
	localparam logic [DATA_W-1:0]    DATA_ONES = '1;
	localparam logic [NUM_W-1:0]     NUM_MAX   = '1;
	localparam int IDLE_PCT     = 22;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_CYCLES = 300;
	localparam int WATCHDOG_MAX = 2000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [FRAGMENTS-1:0] cfg_wdata;

	kftl_req_if req_ch ();
	kftl_rsp_if rsp_ch ();

	keyed_fragment_table_lru dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// predictor copy of the slot table
	logic [KEY_W-1:0]     tbl_key  [SLOTS];
	logic                 tbl_used [SLOTS];
	logic [TIME_W-1:0]    tbl_time [SLOTS];
	logic [ID_W-1:0]      tbl_id   [SLOTS];
	logic [FRAGMENTS-1:0] tbl_flags[SLOTS];
	logic [ID_W-1:0]      id_counter;
	logic [FRAGMENTS-1:0] need_mask;

	rsp_t expected_words[$];

	int  errors;
	int  n_sent;
	int  n_checked;
	int  n_fresh;
	int  n_complete;
	bit  idle_on;
	int  stall_left;
	int  quiet_cycles;
	logic [TIME_W-1:0] now_ts;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// slot lookup, replacement and flag update for one fragment
	function automatic rsp_t table_update(input logic [KEY_W-1:0] key,
		input logic [NUM_W-1:0] num, input logic [TIME_W-1:0] ts);
		rsp_t r;
		int s;
		bit fresh;
		s = -1;
		for (int i = 0; i < SLOTS; i++)
			if (s < 0 && tbl_used[i] && tbl_key[i] == key) s = i;
		fresh = (s < 0);
		for (int i = 0; i < SLOTS; i++)
			if (s < 0 && !tbl_used[i]) s = i;
		// full table: oldest time, lowest index on a tie
		if (s < 0) begin
			s = 0;
			for (int i = 1; i < SLOTS; i++)
				if (tbl_time[i] < tbl_time[s]) s = i;
		end
		if (fresh) begin
			tbl_used[s]  = 1'b1;
			tbl_key[s]   = key;
			tbl_id[s]    = id_counter;
			id_counter   = id_counter + 1'b1;
			tbl_flags[s] = '0;
		end
		if (num >= 1 && num <= FRAGMENTS)
			tbl_flags[s][num - 1] = 1'b1;
		tbl_time[s] = ts;
		r.slot_index     = s[SLOT_W-1:0];
		r.sender_id      = tbl_id[s];
		r.was_new        = fresh;
		r.valid_flags    = tbl_flags[s];
		r.calib_complete = ((tbl_flags[s] & need_mask) == need_mask);
		return r;
	endfunction

	// offer one word, wait for it to be taken, record the expected result
	task automatic send_word(input logic [KEY_W-1:0] key, input logic [NUM_W-1:0] num,
		input logic [DATA_W-1:0] data, input logic [TIME_W-1:0] ts);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 99) < IDLE_PCT) gap = $urandom_range(1, 4);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.frequency_key   <= key;
		req_ch.fragment_number <= num;
		req_ch.fragment_data   <= data;
		req_ch.timestamp       <= ts;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		expected_words.push_back(table_update(key, num, ts));
		n_sent++;
		@(negedge clk);
	endtask

	// drop valid and wait until every expected word is back
	task automatic drain;
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (expected_words.size() > 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_mask(input logic [FRAGMENTS-1:0] mask);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= mask;
		@(negedge clk);
		cfg_we    <= 1'b0;
		need_mask = mask;
		@(negedge clk);
	endtask

	function automatic logic [DATA_W-1:0] rand_data;
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[DATA_W-1:0];
	endfunction

	// field extremes, unused slot with key zero, out-of-range numbers, LRU tie
	task automatic test_edges;
		send_word('0, '0, '0, '0);
		send_word('0, 8'd1, DATA_ONES, 32'd1);
		send_word(KEY_MAX, FRAGMENTS[NUM_W-1:0], DATA_ONES, TIME_MAX);
		send_word(KEY_MAX, FRAGMENTS[NUM_W-1:0] + 8'd1, rand_data(), TIME_MAX);
		send_word(KEY_MAX, NUM_MAX, rand_data(), TIME_MAX);
		// full table: slot 0 is oldest and gets reused
		send_word(32'h1234_5678, 8'd4, rand_data(), 32'd500);
		// equal times: lowest index wins
		send_word(KEY_MAX, 8'd2, rand_data(), 32'd500);
		send_word(32'hCAFE_0001, 8'd9, rand_data(), 32'd700);
		send_word(KEY_MAX, 8'd8, rand_data(), 32'd600);
		send_word(32'hCAFE_0001, 8'd0, rand_data(), 32'd0);
		send_word(32'h1234_5678, 8'd3, rand_data(), 32'd800);
	endtask

	// completion against a sparse mask and the full mask
	task automatic test_complete;
		write_mask(16'h8001);
		send_word(32'h0BAD_F00D, 8'd1, rand_data(), 32'd1000);
		send_word(32'h0BAD_F00D, 8'd16, rand_data(), 32'd1001);
		send_word(32'h0BAD_F00D, 8'd0, rand_data(), 32'd1002);
		write_mask(MASK_ALL);
		send_word(32'h0BAD_F00D, 8'd5, rand_data(), 32'd1003);
	endtask

	// every word a new sender, so the ID counter wraps; no idling here
	task automatic test_id_wrap(input int count);
		logic [KEY_W-1:0] base;
		base = $urandom;
		idle_on = 1'b0;
		for (int i = 0; i < count; i++) begin
			now_ts = now_ts + $urandom_range(1, 20);
			send_word(base + i, NUM_W'($urandom_range(0, 20)), rand_data(), now_ts);
		end
		drain();
		idle_on = 1'b1;
	endtask

	// result side held off while the sender keeps offering words
	task automatic test_backpressure(input int count);
		logic [KEY_W-1:0] k0;
		k0 = $urandom;
		stall_left = STALL_CYCLES;
		for (int i = 0; i < count; i++) begin
			now_ts = now_ts + $urandom_range(1, 20);
			send_word(k0 + (i % 3), NUM_W'($urandom_range(1, FRAGMENTS)), rand_data(),
				now_ts);
		end
		drain();
	endtask

	// mostly well-formed traffic from a small pool of senders, some noise
	task automatic test_random(input logic [FRAGMENTS-1:0] mask, input int senders,
		input int count);
		logic [KEY_W-1:0] pool[4];
		logic [KEY_W-1:0] key;
		logic [NUM_W-1:0] num;
		logic [TIME_W-1:0] ts;
		int pick;
		write_mask(mask);
		for (int i = 0; i < 4; i++) pool[i] = $urandom;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			key  = pool[$urandom_range(0, senders - 1)];
			num  = NUM_W'($urandom_range(1, FRAGMENTS));
			now_ts = now_ts + $urandom_range(1, 50);
			ts   = now_ts;
			if (pick >= 75 && pick < 85) begin
				num = NUM_W'($urandom_range(0, 255));
			end else if (pick >= 85 && pick < 92) begin
				key = $urandom;
			end else if (pick >= 92) begin
				case ($urandom_range(0, 3))
					0: ts = '0;
					1: ts = TIME_MAX;
					2: ts = $urandom;
					default: ts = tbl_time[$urandom_range(0, SLOTS - 1)];
				endcase
			end
			send_word(key, num, rand_data(), ts);
		end
		drain();
	endtask

	// result side: random idling plus the long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// compare each result word with the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (expected_words.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				want = expected_words.pop_front();
				n_checked++;
				if (want.was_new) n_fresh++;
				if (want.calib_complete) n_complete++;
				if (rsp_ch.slot_index !== want.slot_index) begin
					$error("slot_index: expected %0d, got %0d", want.slot_index,
						rsp_ch.slot_index);
					errors++;
				end
				if (rsp_ch.sender_id !== want.sender_id) begin
					$error("sender_id: expected %0d, got %0d", want.sender_id,
						rsp_ch.sender_id);
					errors++;
				end
				if (rsp_ch.was_new !== want.was_new) begin
					$error("was_new: expected %0d, got %0d", want.was_new, rsp_ch.was_new);
					errors++;
				end
				if (rsp_ch.valid_flags !== want.valid_flags) begin
					$error("valid_flags: expected %h, got %h", want.valid_flags,
						rsp_ch.valid_flags);
					errors++;
				end
				if (rsp_ch.calib_complete !== want.calib_complete) begin
					$error("calib_complete: expected %0d, got %0d", want.calib_complete,
						rsp_ch.calib_complete);
					errors++;
				end
			end
		end
	end

	// watchdog: too long without any word moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("timeout: no word moved for %0d cycles", WATCHDOG_MAX);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// test sequence
	initial begin
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_wdata              = '0;
		req_ch.valid           = 1'b0;
		req_ch.frequency_key   = '0;
		req_ch.fragment_number = '0;
		req_ch.fragment_data   = '0;
		req_ch.timestamp       = '0;
		rsp_ch.ready           = 1'b0;
		errors       = 0;
		n_sent       = 0;
		n_checked    = 0;
		n_fresh      = 0;
		n_complete   = 0;
		idle_on      = 1'b1;
		stall_left   = 0;
		quiet_cycles = 0;
		now_ts       = 32'd2000;
		id_counter   = '0;
		need_mask    = MASK_NONE;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_key[i]   = '0;
			tbl_used[i]  = 1'b0;
			tbl_time[i]  = '0;
			tbl_id[i]    = '0;
			tbl_flags[i] = '0;
		end
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_edges();
		test_complete();
		test_id_wrap(300);
		test_backpressure(40);
		test_random(MASK_ALL, 2, 300);
		test_random(16'($urandom), 3, 290);
		test_random(16'(1) << $urandom_range(0, FRAGMENTS - 1), 3, 290);
		test_random(MASK_NONE, 4, 290);
		drain();

		$display("%0d fragments sent, %0d results checked", n_sent, n_checked);
		$display("(%0d new or reused slots, %0d complete)", n_fresh, n_complete);
		$display("covered LRU reuse and ties, ID wrap, out-of-range numbers, long backpressure");
		if (errors == 0 && expected_words.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
